/* hw/rtl/assert_macros.svh */
// Assertion macros for RTL files that check their own behavior.
// The macros expect signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VNA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VNA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/vna_pkg.sv */
// Package for the vertex normal accumulator: widths, command codes and the
// command and status types between controller and datapath. No dependencies.
package vna_pkg;

    localparam int NUM_VERTS_DEF = 1024;

    localparam int IDX_W   = 10;
    localparam int COORD_W = 16;
    localparam int VTX_W   = 3 * COORD_W;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int FN_W    = 35;
    localparam int ACC_W   = 48;
    localparam int ROW_W   = 3 * ACC_W + 1;
    localparam int TN_W    = 30;
    localparam int SQ_W    = 60;
    localparam int LEN_W   = 62;
    localparam int RES_W   = 63;
    localparam int ROOT_W  = 32;
    localparam int NUM_W   = 46;
    localparam int DEN_W   = 48;
    localparam int Q_W     = 16;
    localparam int NORM_W  = 16;
    localparam int STEP_W  = 6;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 3 * NORM_W;
    localparam int M_TUSER_W = 2;

    localparam int CORNERS    = 3;
    localparam int MUL_STEPS  = 6;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 16;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TRI  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    localparam logic [Q_W-1:0] Q_ONE = 16'd16384;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_VTX_WR,
        OP_VTX_LATCH,
        OP_MUL,
        OP_MACC,
        OP_ACC_WR,
        OP_CLEAR,
        OP_SUM_LATCH,
        OP_SHIFT,
        OP_SQ,
        OP_SQ_ACC,
        OP_ROOT_INIT,
        OP_ROOT,
        OP_DIV_INIT,
        OP_DIV,
        OP_DIV_STORE,
        OP_OUT_NORM,
        OP_OUT_DEGEN,
        OP_OUT_ZERO
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [1:0]        sel;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic a_ok;
        logic tri_ok;
        logic mag_zero;
        logic mag_high;
        logic mag_low;
    } dp_stat_t;

endpackage

/* hw/rtl/vna_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vna_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/vna_dp.sv */
// Datapath: vertex and accumulator RAMs, cross product, saturating adds,
// normalization, square root and division. Depends on vna_pkg and vna_ram.
module vna_dp #(
    parameter int NUM_VERTS = vna_pkg::NUM_VERTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  vna_pkg::dp_cmd_t               cmd,
    output vna_pkg::dp_stat_t              stat,
    input  logic [vna_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic [vna_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [vna_pkg::M_TUSER_W-1:0]  m_tuser
);

    localparam int AW = $clog2(NUM_VERTS);
    localparam int IW = vna_pkg::IDX_W;
    localparam int CW = vna_pkg::COORD_W;
    localparam int AC = vna_pkg::ACC_W;

    logic [IW-1:0]                 idx_reg [3];
    logic [vna_pkg::VTX_W-1:0]     coord_reg;
    logic [vna_pkg::VTX_W-1:0]     pt_reg [3];
    logic signed [vna_pkg::PROD_W-1:0] prod_reg;
    logic signed [vna_pkg::FN_W-1:0]   fn_reg [3];
    logic [AC-1:0]                 t_reg [3];
    logic                          neg_reg [3];
    logic                          sat_reg;
    logic [vna_pkg::SQ_W-1:0]      sq_reg;
    logic [vna_pkg::LEN_W-1:0]     len_reg;
    logic [vna_pkg::LEN_W-1:0]     rem_reg;
    logic [vna_pkg::RES_W-1:0]     res_reg;
    logic [vna_pkg::RES_W-1:0]     bit_reg;
    logic [vna_pkg::NUM_W-1:0]     num_reg;
    logic [vna_pkg::DEN_W-1:0]     den_reg;
    logic [vna_pkg::Q_W-1:0]       q_reg;
    logic [vna_pkg::NORM_W-1:0]    n_reg [3];
    logic [vna_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [vna_pkg::M_TUSER_W-1:0] m_tuser_reg;
    logic [AW-1:0]                 clr_addr_reg;

    logic [AW-1:0]                 addr [3];
    logic                          ok [3];
    logic signed [vna_pkg::DIFF_W-1:0] d1 [3];
    logic signed [vna_pkg::DIFF_W-1:0] d2 [3];
    logic signed [vna_pkg::DIFF_W-1:0] mul_a;
    logic signed [vna_pkg::DIFF_W-1:0] mul_b;
    logic                          vtx_we;
    logic [vna_pkg::VTX_W-1:0]     vtx_rdata;
    logic                          acc_we;
    logic [AW-1:0]                 acc_waddr;
    logic [vna_pkg::ROW_W-1:0]     acc_wdata;
    logic [vna_pkg::ROW_W-1:0]     acc_rdata;
    logic [vna_pkg::ROW_W-1:0]     acc_new;
    logic [2:0]                    clip;
    logic [AC:0]                   sum49 [3];
    logic [63:0]                   trial;
    logic [vna_pkg::ROOT_W-1:0]    root;
    logic                          div_ge;
    logic [vna_pkg::Q_W-1:0]       q_clamp;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            addr[k] = AW'(idx_reg[k]);
            ok[k]   = 32'(idx_reg[k]) < 32'(NUM_VERTS);
        end
        for (int j = 0; j < 3; j++)
        begin
            d1[j] = vna_pkg::DIFF_W'($signed(pt_reg[1][CW*j +: CW]))
                  - vna_pkg::DIFF_W'($signed(pt_reg[0][CW*j +: CW]));
            d2[j] = vna_pkg::DIFF_W'($signed(pt_reg[2][CW*j +: CW]))
                  - vna_pkg::DIFF_W'($signed(pt_reg[0][CW*j +: CW]));
        end
    end

    always_comb
    begin
        case (cmd.step[2:0])
            3'd0:
            begin
                mul_a = d1[1];
                mul_b = d2[2];
            end
            3'd1:
            begin
                mul_a = d1[2];
                mul_b = d2[1];
            end
            3'd2:
            begin
                mul_a = d1[2];
                mul_b = d2[0];
            end
            3'd3:
            begin
                mul_a = d1[0];
                mul_b = d2[2];
            end
            3'd4:
            begin
                mul_a = d1[0];
                mul_b = d2[1];
            end
            3'd5:
            begin
                mul_a = d1[1];
                mul_b = d2[0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign vtx_we = (cmd.op == vna_pkg::OP_VTX_WR) && ok[0];

    vna_ram #(
        .WIDTH (vna_pkg::VTX_W),
        .DEPTH (NUM_VERTS)
    ) u_vtx_ram (
        .clk   (clk),
        .we    (vtx_we),
        .waddr (addr[0]),
        .wdata (coord_reg),
        .raddr (addr[cmd.sel]),
        .rdata (vtx_rdata)
    );

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum49[j] = (AC+1)'($signed(acc_rdata[AC*j +: AC])) + (AC+1)'(fn_reg[j]);
            clip[j]  = sum49[j][AC] != sum49[j][AC-1];
            if (clip[j])
            begin
                acc_new[AC*j +: AC] = sum49[j][AC] ? {1'b1, {(AC-1){1'b0}}}
                                                   : {1'b0, {(AC-1){1'b1}}};
            end
            else
            begin
                acc_new[AC*j +: AC] = sum49[j][AC-1:0];
            end
        end
        acc_new[3*AC] = acc_rdata[3*AC] | (|clip);
    end

    assign acc_we    = (cmd.op == vna_pkg::OP_CLEAR) || (cmd.op == vna_pkg::OP_ACC_WR);
    assign acc_waddr = (cmd.op == vna_pkg::OP_CLEAR) ? clr_addr_reg : addr[cmd.sel];
    assign acc_wdata = (cmd.op == vna_pkg::OP_CLEAR) ? '0 : acc_new;

    vna_ram #(
        .WIDTH (vna_pkg::ROW_W),
        .DEPTH (NUM_VERTS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (addr[cmd.sel]),
        .rdata (acc_rdata)
    );

    assign trial   = 64'(res_reg) + 64'(bit_reg);
    assign root    = res_reg[vna_pkg::ROOT_W-1:0];
    assign div_ge  = vna_pkg::DEN_W'(num_reg) >= den_reg;
    assign q_clamp = (q_reg > vna_pkg::Q_ONE) ? vna_pkg::Q_ONE : q_reg;

    always_comb
    begin
        stat.clr_last = clr_addr_reg == AW'(NUM_VERTS - 1);
        stat.a_ok     = ok[0];
        stat.tri_ok   = ok[0] && ok[1] && ok[2];
        stat.mag_zero = (t_reg[0] == '0) && (t_reg[1] == '0) && (t_reg[2] == '0);
        stat.mag_high = (|t_reg[0][AC-1:30]) || (|t_reg[1][AC-1:30]) || (|t_reg[2][AC-1:30]);
        stat.mag_low  = !((|t_reg[0][AC-1:29]) || (|t_reg[1][AC-1:29])
                        || (|t_reg[2][AC-1:29]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.op == vna_pkg::OP_CLEAR)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            vna_pkg::OP_CAPTURE:
            begin
                idx_reg[0] <= s_tdata[IW-1:0];
                idx_reg[1] <= s_tdata[2*IW-1:IW];
                idx_reg[2] <= s_tdata[3*IW-1:2*IW];
                coord_reg  <= s_tdata[3*IW +: vna_pkg::VTX_W];
            end
            vna_pkg::OP_VTX_LATCH:
            begin
                pt_reg[cmd.sel] <= vtx_rdata;
            end
            vna_pkg::OP_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            vna_pkg::OP_MACC:
            begin
                if (!cmd.step[0])
                begin
                    fn_reg[cmd.step[2:1]] <= vna_pkg::FN_W'(prod_reg);
                end
                else
                begin
                    fn_reg[cmd.step[2:1]] <= fn_reg[cmd.step[2:1]]
                                           - vna_pkg::FN_W'(prod_reg);
                end
            end
            vna_pkg::OP_SUM_LATCH:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    neg_reg[j] <= acc_rdata[AC*j + AC - 1];
                    t_reg[j]   <= acc_rdata[AC*j + AC - 1] ? (AC'(0) - acc_rdata[AC*j +: AC])
                                                           : acc_rdata[AC*j +: AC];
                end
                sat_reg <= acc_rdata[3*AC];
            end
            vna_pkg::OP_SHIFT:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    t_reg[j] <= stat.mag_high ? (t_reg[j] >> 1) : (t_reg[j] << 1);
                end
            end
            vna_pkg::OP_SQ:
            begin
                sq_reg <= t_reg[cmd.step[1:0]][vna_pkg::TN_W-1:0]
                        * t_reg[cmd.step[1:0]][vna_pkg::TN_W-1:0];
            end
            vna_pkg::OP_SQ_ACC:
            begin
                len_reg <= ((cmd.step == '0) ? '0 : len_reg) + vna_pkg::LEN_W'(sq_reg);
            end
            vna_pkg::OP_ROOT_INIT:
            begin
                rem_reg <= len_reg;
                res_reg <= '0;
                bit_reg <= vna_pkg::RES_W'(1) << 62;
            end
            vna_pkg::OP_ROOT:
            begin
                if (64'(rem_reg) >= trial)
                begin
                    rem_reg <= rem_reg - vna_pkg::LEN_W'(trial);
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            vna_pkg::OP_DIV_INIT:
            begin
                num_reg <= vna_pkg::NUM_W'({t_reg[cmd.sel][vna_pkg::TN_W-1:0], 15'b0})
                         + vna_pkg::NUM_W'(root);
                den_reg <= vna_pkg::DEN_W'({root, 16'b0});
                q_reg   <= '0;
            end
            vna_pkg::OP_DIV:
            begin
                if (div_ge)
                begin
                    num_reg <= num_reg - vna_pkg::NUM_W'(den_reg);
                end
                q_reg   <= {q_reg[vna_pkg::Q_W-2:0], div_ge};
                den_reg <= den_reg >> 1;
            end
            vna_pkg::OP_DIV_STORE:
            begin
                n_reg[cmd.sel] <= neg_reg[cmd.sel] ? (vna_pkg::NORM_W'(0) - q_clamp) : q_clamp;
            end
            vna_pkg::OP_OUT_NORM:
            begin
                m_tdata_reg <= {n_reg[2], n_reg[1], n_reg[0]};
                m_tuser_reg <= {sat_reg, 1'b0};
            end
            vna_pkg::OP_OUT_DEGEN:
            begin
                m_tdata_reg <= '0;
                m_tuser_reg <= {sat_reg, 1'b1};
            end
            vna_pkg::OP_OUT_ZERO:
            begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 2'b01;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

/* hw/rtl/vna_ctrl.sv */
// Controller state machine that sequences the datapath and owns both
// handshakes. Depends on vna_pkg.
module vna_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vna_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output vna_pkg::dp_cmd_t              cmd,
    input  vna_pkg::dp_stat_t             stat
);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_VWR, ST_TCHK, ST_VRD, ST_VLAT, ST_MUL, ST_MACC,
        ST_ARD, ST_AWR, ST_RCHK, ST_SRD, ST_SLAT, ST_NORM, ST_SQ, ST_SQACC,
        ST_RINIT, ST_ROOT, ST_DINIT, ST_DIV, ST_DST, ST_NOUT, ST_DOUT, ST_ZOUT
    } state_t;

    localparam int SW = vna_pkg::STEP_W;

    state_t               state_reg, state_next;
    logic [SW-1:0]        cnt_reg, cnt_next;
    logic [1:0]           comp_reg, comp_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        comp_next     = comp_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.op        = vna_pkg::OP_NONE;
        cmd.sel       = comp_reg;
        cmd.step      = cnt_reg;
        s_tready      = state_reg == ST_IDLE;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = vna_pkg::OP_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op = vna_pkg::OP_CAPTURE;
                    case (s_tuser)
                        vna_pkg::CMD_LOAD: state_next = ST_VWR;
                        vna_pkg::CMD_TRI:  state_next = ST_TCHK;
                        vna_pkg::CMD_READ: state_next = ST_RCHK;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_VWR:
            begin
                cmd.op     = vna_pkg::OP_VTX_WR;
                state_next = ST_IDLE;
            end
            ST_TCHK:
            begin
                comp_next  = 2'd0;
                cnt_next   = '0;
                state_next = stat.tri_ok ? ST_VRD : ST_IDLE;
            end
            ST_VRD:
            begin
                state_next = ST_VLAT;
            end
            ST_VLAT:
            begin
                cmd.op = vna_pkg::OP_VTX_LATCH;
                if (comp_reg == 2'(vna_pkg::CORNERS - 1))
                begin
                    comp_next  = 2'd0;
                    state_next = ST_MUL;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_VRD;
                end
            end
            ST_MUL:
            begin
                cmd.op     = vna_pkg::OP_MUL;
                state_next = ST_MACC;
            end
            ST_MACC:
            begin
                cmd.op = vna_pkg::OP_MACC;
                if (cnt_reg == SW'(vna_pkg::MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_ARD;
                end
                else
                begin
                    cnt_next   = cnt_reg + SW'(1);
                    state_next = ST_MUL;
                end
            end
            ST_ARD:
            begin
                state_next = ST_AWR;
            end
            ST_AWR:
            begin
                cmd.op = vna_pkg::OP_ACC_WR;
                if (comp_reg == 2'(vna_pkg::CORNERS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_ARD;
                end
            end
            ST_RCHK:
            begin
                comp_next  = 2'd0;
                cnt_next   = '0;
                state_next = stat.a_ok ? ST_SRD : ST_ZOUT;
            end
            ST_SRD:
            begin
                state_next = ST_SLAT;
            end
            ST_SLAT:
            begin
                cmd.op     = vna_pkg::OP_SUM_LATCH;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (stat.mag_zero)
                begin
                    state_next = ST_DOUT;
                end
                else if (stat.mag_high || stat.mag_low)
                begin
                    cmd.op = vna_pkg::OP_SHIFT;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.op     = vna_pkg::OP_SQ;
                state_next = ST_SQACC;
            end
            ST_SQACC:
            begin
                cmd.op = vna_pkg::OP_SQ_ACC;
                if (cnt_reg == SW'(vna_pkg::CORNERS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_RINIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + SW'(1);
                    state_next = ST_SQ;
                end
            end
            ST_RINIT:
            begin
                cmd.op     = vna_pkg::OP_ROOT_INIT;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.op = vna_pkg::OP_ROOT;
                if (cnt_reg == SW'(vna_pkg::ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    comp_next  = 2'd0;
                    state_next = ST_DINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + SW'(1);
                end
            end
            ST_DINIT:
            begin
                cmd.op     = vna_pkg::OP_DIV_INIT;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = vna_pkg::OP_DIV;
                if (cnt_reg == SW'(vna_pkg::DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DST;
                end
                else
                begin
                    cnt_next = cnt_reg + SW'(1);
                end
            end
            ST_DST:
            begin
                cmd.op = vna_pkg::OP_DIV_STORE;
                if (comp_reg == 2'(vna_pkg::CORNERS - 1))
                begin
                    state_next = ST_NOUT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_DINIT;
                end
            end
            ST_NOUT:
            begin
                if (out_free)
                begin
                    cmd.op        = vna_pkg::OP_OUT_NORM;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DOUT:
            begin
                if (out_free)
                begin
                    cmd.op        = vna_pkg::OP_OUT_DEGEN;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_ZOUT:
            begin
                if (out_free)
                begin
                    cmd.op        = vna_pkg::OP_OUT_ZERO;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            comp_reg     <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            comp_reg     <= comp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

/* hw/rtl/vertex_normal_accumulator.sv */
// Channel | Dir | Signals                     | Beat
// s       | in  | s_tvalid/tready/tdata/tuser | one command
// m       | out | m_tvalid/tready/tdata/tuser | one normalized vertex normal
//
// The read time is set by the one-bit-per-cycle shift, the 32-step square root and three
// 16-step divisions. After reset every row of the accumulator RAM is cleared while
// s_tready is low. One result may wait in the output register while the next command
// is taken.
// Top level of the vertex normal accumulator. Depends on vna_pkg, vna_ctrl,
// vna_dp and assert_macros.svh.
`include "assert_macros.svh"

module vertex_normal_accumulator #(
    parameter int NUM_VERTS = vna_pkg::NUM_VERTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Bits from low: vertex_a, vertex_b, vertex_c, coord_x, coord_y, coord_z, zero pad.
    input  logic [vna_pkg::S_TDATA_W-1:0] s_tdata,
    // Bits from low: cmd.
    input  logic [vna_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Bits from low: normal_x, normal_y, normal_z.
    output logic [vna_pkg::M_TDATA_W-1:0] m_tdata,
    // Bits from low: degenerate, saturated.
    output logic [vna_pkg::M_TUSER_W-1:0] m_tuser
);

    vna_pkg::dp_cmd_t  cmd;
    vna_pkg::dp_stat_t stat;

    vna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    vna_dp #(
        .NUM_VERTS (NUM_VERTS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    `VNA_ASSERT_IMP(a_degen_zero, m_tvalid && m_tuser[0], m_tdata == '0, "degenerate result with nonzero normal")
    `VNA_ASSERT_IMP(a_norm_range, m_tvalid && !m_tuser[0], ($signed(m_tdata[15:0]) <= 16'sd16384) && ($signed(m_tdata[15:0]) >= -16'sd16384) && ($signed(m_tdata[31:16]) <= 16'sd16384) && ($signed(m_tdata[31:16]) >= -16'sd16384) && ($signed(m_tdata[47:32]) <= 16'sd16384) && ($signed(m_tdata[47:32]) >= -16'sd16384), "normal component out of range")
    `VNA_ASSERT_NXT(a_busy_after_cmd, s_tvalid && s_tready && (s_tuser != vna_pkg::CMD_NOP), !s_tready, "command accepted while busy")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for vertex_normal_accumulator: it drives command beats,
// predicts the area-weighted normals and checks every result beat.
// Depends on vna_pkg and the vertex_normal_accumulator RTL.
`timescale 1ns / 100ps

typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    bit                 degen;
    bit                 sat;
} normal_beat_t;

class normal_scoreboard;
    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    logic [47:0]  coords [1024];
    longint       acc    [1024][3];
    bit           sat_flag [1024];
    normal_beat_t pending [$];
    int           errors;

    function new();
        for (int i = 0; i < 1024; i++)
        begin
            coords[i] = '0;
            sat_flag[i] = 1'b0;
            for (int k = 0; k < 3; k++)
                acc[i][k] = 0;
        end
        errors = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
        longint unsigned rem, res, b;
        rem = x;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function void note(logic [1:0] cmd, int a, int b, int c, logic [15:0] x,
                       logic [15:0] y, logic [15:0] z);
        longint p [3][3];
        longint d1 [3];
        longint d2 [3];
        longint fn [3];
        longint s;
        longint unsigned t [3];
        longint unsigned m, len2, r, q;
        int idx [3];
        bit clip;
        normal_beat_t e;
        if (cmd == vna_pkg::CMD_LOAD)
            coords[a] = {z, y, x};
        else if (cmd == vna_pkg::CMD_TRI)
        begin
            idx[0] = a;
            idx[1] = b;
            idx[2] = c;
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    p[k][j] = longint'($signed(coords[idx[k]][16*j +: 16]));
            for (int j = 0; j < 3; j++)
            begin
                d1[j] = p[1][j] - p[0][j];
                d2[j] = p[2][j] - p[0][j];
            end
            fn[0] = d1[1] * d2[2] - d1[2] * d2[1];
            fn[1] = d1[2] * d2[0] - d1[0] * d2[2];
            fn[2] = d1[0] * d2[1] - d1[1] * d2[0];
            for (int k = 0; k < 3; k++)
            begin
                clip = 1'b0;
                for (int j = 0; j < 3; j++)
                begin
                    s = acc[idx[k]][j] + fn[j];
                    if (s > ACC_HI)
                    begin
                        s = ACC_HI;
                        clip = 1'b1;
                    end
                    else if (s < ACC_LO)
                    begin
                        s = ACC_LO;
                        clip = 1'b1;
                    end
                    acc[idx[k]][j] = s;
                end
                if (clip)
                    sat_flag[idx[k]] = 1'b1;
            end
        end
        else if (cmd == vna_pkg::CMD_READ)
        begin
            e.nx = '0;
            e.ny = '0;
            e.nz = '0;
            e.degen = 1'b0;
            e.sat = sat_flag[a];
            m = 0;
            for (int j = 0; j < 3; j++)
            begin
                t[j] = (acc[a][j] < 0) ? -acc[a][j] : acc[a][j];
                if (t[j] > m)
                    m = t[j];
            end
            if (m == 0)
                e.degen = 1'b1;
            else
            begin
                while (m >= (64'd1 << 30))
                begin
                    for (int j = 0; j < 3; j++)
                        t[j] >>= 1;
                    m >>= 1;
                end
                while (m < (64'd1 << 29))
                begin
                    for (int j = 0; j < 3; j++)
                        t[j] <<= 1;
                    m <<= 1;
                end
                len2 = t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
                r = int_sqrt(len2);
                for (int j = 0; j < 3; j++)
                begin
                    q = (64'd32768 * t[j] + r) / (2 * r);
                    if (q > 16384)
                        q = 16384;
                    if (acc[a][j] < 0)
                        q = -q;
                    case (j)
                        0: e.nx = q[15:0];
                        1: e.ny = q[15:0];
                        default: e.nz = q[15:0];
                    endcase
                end
            end
            pending = {pending, e};
        end
    endfunction

    function void check(normal_beat_t got);
        normal_beat_t e;
        if (pending.size() == 0)
        begin
            $error("Result beat with no expected normal: nx %0d ny %0d nz %0d",
                   got.nx, got.ny, got.nz);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.nx !== e.nx)
        begin
            $error("normal_x expected %0d actual %0d", e.nx, got.nx);
            errors++;
        end
        if (got.ny !== e.ny)
        begin
            $error("normal_y expected %0d actual %0d", e.ny, got.ny);
            errors++;
        end
        if (got.nz !== e.nz)
        begin
            $error("normal_z expected %0d actual %0d", e.nz, got.nz);
            errors++;
        end
        if (got.degen !== e.degen)
        begin
            $error("degenerate expected %0d actual %0d", e.degen, got.degen);
            errors++;
        end
        if (got.sat !== e.sat)
        begin
            $error("saturated expected %0d actual %0d", e.sat, got.sat);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int STALL_LIMIT = 5000;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [vna_pkg::S_TDATA_W-1:0] s_tdata;
    logic [vna_pkg::S_TUSER_W-1:0] s_tuser;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [vna_pkg::M_TDATA_W-1:0] m_tdata;
    logic [vna_pkg::M_TUSER_W-1:0] m_tuser;

    normal_scoreboard normals;
    bit               idling;
    int               stall_left = 0;
    int               quiet_cycles = 0;
    bit               loaded [1024];
    int               loaded_list [$];
    normal_beat_t     got;

    vertex_normal_accumulator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic send(logic [1:0] cmd, int a, int b, int c, logic [15:0] x,
                        logic [15:0] y, logic [15:0] z);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, z, y, x, c[9:0], b[9:0], a[9:0]};
        do
            @(posedge clk);
        while (!s_tready);
        normals.note(cmd, a, b, c, x, y, z);
        if (cmd == vna_pkg::CMD_LOAD && !loaded[a])
        begin
            loaded[a] = 1'b1;
            loaded_list = {loaded_list, a};
        end
        @(negedge clk);
    endtask

    task automatic load(int a, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        send(vna_pkg::CMD_LOAD, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
             x, y, z);
    endtask

    task automatic tri_add(int a, int b, int c);
        send(vna_pkg::CMD_TRI, a, b, c, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic read(int a);
        send(vna_pkg::CMD_READ, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
             16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.nx = m_tdata[15:0];
            got.ny = m_tdata[31:16];
            got.nz = m_tdata[47:32];
            got.degen = m_tuser[0];
            got.sat = m_tuser[1];
            normals.check(got);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL vertex_normal_accumulator");
            $finish;
        end
    end

    initial
    begin
        int op;
        int h;
        normals = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        idling = 1'b1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extreme coordinates, repeated corners, an unused command and a
        // read of a vertex that never got a face.
        load(0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        load(1, 16'h8000, 16'h8000, 16'h8000);
        load(2, 16'h7FFF, 16'h8000, 16'h0000);
        load(1023, 16'h0100, 16'hFF00, 16'h8000);
        load(3, 16'h0000, 16'h0000, 16'h0000);
        read(500);
        read(1023);
        tri_add(0, 1, 2);
        tri_add(1023, 2, 3);
        tri_add(0, 0, 1);
        tri_add(3, 3, 3);
        read(0);
        read(1);
        read(2);
        read(3);
        read(1023);
        send(vna_pkg::CMD_NOP, 1023, 1023, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tri_add(2, 0, 1);
        read(0);
        read(2);

        for (int i = 0; i < 820; i++)
        begin
            if (i == 680)
                idling = 1'b0;
            op = $urandom_range(0, 99);
            h = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
            if (op < 25)
                load(h, 16'($urandom), 16'($urandom), 16'($urandom));
            else if (op < 65)
            begin
                if ($urandom_range(0, 9) == 0)
                    tri_add(pick_loaded(), pick_loaded(), pick_loaded());
                else
                    tri_add(pick_loaded(), pick_loaded(), pick_loaded());
            end
            else if (op < 95)
                read(($urandom_range(0, 2) != 0) ? pick_loaded() : h);
            else
                send(vna_pkg::CMD_NOP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), 16'($urandom), 16'($urandom), 16'($urandom));
        end

        // A few of the largest faces, positive on x and negative on y and z.
        load(1000, 16'h8000, 16'h8000, 16'h8000);
        load(1001, 16'h7FFF, 16'h7FFF, 16'h8000);
        load(1002, 16'h7FFF, 16'h8000, 16'h7FFF);
        read(1000);
        for (int i = 0; i < 4; i++)
            tri_add(1000, 1001, 1002);
        read(1000);
        read(1001);
        read(1002);
        tri_add(1002, 1001, 1000);
        read(1001);
        s_tvalid <= 1'b0;

        while (normals.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (normals.errors == 0)
            $display("PASS vertex_normal_accumulator");
        else
            $display("FAIL vertex_normal_accumulator");
        $finish;
    end
endmodule
